/* sv/usbc_pkg.sv */
// Package for the USB client register file: item types, register map
// constants and the decode result passed between the decoder and the registers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package usbc_pkg;

  localparam int NUM_ENDPOINTS_DEF = 23;

  localparam logic [19:0] MAP_END = 20'h00460;

  // word indexes (byte offset >> 2)
  localparam logic [8:0] W_CTRL = 9'h000;
  localparam logic [8:0] W_IEL  = 9'h001;
  localparam logic [8:0] W_IEH  = 9'h002;
  localparam logic [8:0] W_OTG  = 9'h006;
  localparam logic [8:0] W_P2   = 9'h008;
  localparam logic [8:0] W_P3   = 9'h009;
  localparam logic [8:0] W_EP0  = 9'h040;
  localparam logic [8:0] W_EPS  = 9'h041;
  localparam logic [8:0] W_EPC  = 9'h101;

  localparam logic [31:0] CTRL_RW    = 32'h8000_0001;
  localparam logic [31:0] IEH_RW     = 32'hF800_FFFF;
  localparam logic [24:0] OTG_RW     = 25'h10303FF;
  localparam logic [26:0] P2_RW      = 27'h70307FF;
  localparam logic [26:0] P2_RESET   = 27'h0030000;
  localparam logic [9:0]  EP0_RW     = 10'h208;
  localparam logic [9:0]  EP0_SET    = 10'h122;
  localparam int          EP0_DONE   = 2;
  localparam int          EP0_INPROG = 1;
  localparam logic [7:0]  EPS_RW     = 8'h28;
  localparam logic [7:0]  EPS_STICKY = 8'h80;
  localparam logic [7:0]  EPS_IDLE   = 8'h41;
  localparam int          EPC_DIR_IN = 12;
  localparam int          EPC_ENABLE = 0;
  localparam int          CTRL_ENABLE = 0;

  typedef enum logic [3:0] {
    SEL_NONE,
    SEL_CTRL,
    SEL_IEL,
    SEL_IEH,
    SEL_OTG,
    SEL_P2,
    SEL_P3,
    SEL_EP0,
    SEL_EPS,
    SEL_EPC
  } reg_sel_t;

  typedef struct packed {
    logic        action;
    logic [19:0] offset;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_error;
  } out_item_t;

  typedef struct packed {
    logic       err;
    logic       wr;
    reg_sel_t   sel;
    logic [8:0] ep_rel;
  } dec_t;

endpackage

`default_nettype wire

/* sv/usb_client_register_file_unit.sv */
// Top level of the USB client register file: input register, decode,
// register storage and result register. Depends on usbc_pkg, usbc_decode, usbc_regs.
//
// One word read or write per item. An accepted item is held in an input
// register; when the output register is free or being taken, it is decoded,
// the register state is updated and the result is loaded into the output
// register. One item is accepted every cycle while the result side keeps
// taking items. Each access sees every earlier write. Misaligned offsets or
// offsets at or beyond 0x460 return access_error with zero data and change
// nothing.
`timescale 1ns / 1ps
`default_nettype none

module usb_client_register_file_unit
  import usbc_pkg::*;
#(
  parameter int NUM_ENDPOINTS = NUM_ENDPOINTS_DEF
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire           out_ready,
  output out_item_t     out_item
);

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t out_item_nxt;
  logic      advance;
  dec_t      dec;
  logic [31:0] rdata;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  usbc_decode #(
    .NUM_ENDPOINTS(NUM_ENDPOINTS)
  ) u_decode (
    .item (s1_item_r),
    .dec  (dec)
  );

  usbc_regs #(
    .NUM_ENDPOINTS(NUM_ENDPOINTS)
  ) u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .dec   (dec),
    .wdata (s1_item_r.write_data),
    .rdata (rdata)
  );

  always_comb begin
    out_item_nxt.access_error = dec.err;
    out_item_nxt.read_data    = (dec.err || dec.wr) ? 32'd0 : rdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/usbc_decode.sv */
// Address decoder: turns an access item into a register select and endpoint slot.
// Depends on usbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module usbc_decode
  import usbc_pkg::*;
#(
  parameter int NUM_ENDPOINTS = NUM_ENDPOINTS_DEF
) (
  input  wire in_item_t item,
  output dec_t          dec
);

  logic [8:0] word;
  logic [8:0] rel_s;
  logic [8:0] rel_c;
  logic       hit_s;
  logic       hit_c;

  assign word  = item.offset[10:2];
  assign rel_s = word - W_EPS;
  assign rel_c = word - W_EPC;
  assign hit_s = (word >= W_EPS) && (rel_s < 9'(NUM_ENDPOINTS));
  assign hit_c = (word >= W_EPC) && (rel_c < 9'(NUM_ENDPOINTS));

  always_comb begin
    dec.err    = (item.offset >= MAP_END) || (item.offset[1:0] != 2'b00);
    dec.wr     = item.action;
    dec.ep_rel = hit_s ? rel_s : rel_c;
    if (hit_s) begin
      dec.sel = SEL_EPS;
    end else if (hit_c) begin
      dec.sel = SEL_EPC;
    end else begin
      case (word)
        W_CTRL:  dec.sel = SEL_CTRL;
        W_IEL:   dec.sel = SEL_IEL;
        W_IEH:   dec.sel = SEL_IEH;
        W_OTG:   dec.sel = SEL_OTG;
        W_P2:    dec.sel = SEL_P2;
        W_P3:    dec.sel = SEL_P3;
        W_EP0:   dec.sel = SEL_EP0;
        default: dec.sel = SEL_NONE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/usbc_regs.sv */
// Register storage and read mux: control, interrupt enables, port controls,
// endpoint-0 status and per-endpoint status/config. Depends on usbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module usbc_regs
  import usbc_pkg::*;
#(
  parameter int NUM_ENDPOINTS = NUM_ENDPOINTS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         en,
  input  wire dec_t   dec,
  input  wire  [31:0] wdata,
  output logic [31:0] rdata
);

  localparam int EP_IW = (NUM_ENDPOINTS > 1) ? $clog2(NUM_ENDPOINTS) : 1;

  logic [31:0] ctrl_r;
  logic [31:0] iel_r;
  logic [31:0] ieh_r;
  logic [24:0] otg_r;
  logic [26:0] p2_r;
  logic [1:0]  p3_r;
  logic [9:0]  ep0_r;
  logic [7:0]  eps_r [NUM_ENDPOINTS];
  logic [26:0] epc_r [NUM_ENDPOINTS];

  logic [EP_IW-1:0] idx;
  logic [7:0]       eps_cur;
  logic [26:0]      epc_cur;
  logic [7:0]       eps_nxt;
  logic [9:0]       ep0_nxt;
  logic             do_wr;

  assign idx     = dec.ep_rel[EP_IW-1:0];
  assign eps_cur = eps_r[idx];
  assign epc_cur = epc_r[idx];
  assign do_wr   = en && dec.wr && !dec.err;

  always_comb begin
    eps_nxt = (wdata[7:0] & EPS_RW) | (eps_cur & EPS_STICKY);
    if (epc_cur[EPC_DIR_IN]) begin
      eps_nxt = eps_nxt | (wdata[7:0] & EPS_STICKY);
    end
    ep0_nxt = (wdata[9:0] & EP0_RW) | (ep0_r & EP0_SET) | (wdata[9:0] & EP0_SET);
    if (wdata[EP0_DONE]) begin
      ep0_nxt[EP0_INPROG] = 1'b0;
    end
  end

  always_comb begin
    case (dec.sel)
      SEL_CTRL: rdata = ctrl_r;
      SEL_IEL:  rdata = iel_r;
      SEL_IEH:  rdata = ieh_r;
      SEL_OTG:  rdata = {7'd0, otg_r};
      SEL_P2:   rdata = {5'd0, p2_r};
      SEL_P3:   rdata = {30'd0, p3_r};
      SEL_EP0:  rdata = {22'd0, ep0_r};
      SEL_EPS:  rdata = {24'd0, eps_cur |
                         ((epc_cur[EPC_DIR_IN] && epc_cur[EPC_ENABLE]) ? EPS_IDLE : 8'h00)};
      SEL_EPC:  rdata = {5'd0, epc_cur};
      default:  rdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
      iel_r  <= '0;
      ieh_r  <= '0;
      otg_r  <= '0;
      p2_r   <= P2_RESET;
      p3_r   <= '0;
      ep0_r  <= '0;
      for (int i = 0; i < NUM_ENDPOINTS; i++) begin
        eps_r[i] <= '0;
        epc_r[i] <= '0;
      end
    end else if (do_wr) begin
      case (dec.sel)
        SEL_CTRL: ctrl_r <= wdata & CTRL_RW;
        SEL_IEL:  iel_r  <= wdata;
        SEL_IEH:  ieh_r  <= wdata & IEH_RW;
        SEL_OTG:  otg_r  <= wdata[24:0] & OTG_RW;
        SEL_P2:   p2_r   <= wdata[26:0] & P2_RW;
        SEL_P3:   p3_r   <= wdata[1:0];
        SEL_EP0:  ep0_r  <= ep0_nxt;
        SEL_EPS:  eps_r[idx] <= eps_nxt;
        SEL_EPC: begin
          if (!ctrl_r[CTRL_ENABLE]) begin
            epc_r[idx] <= wdata[26:0];
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sim/usbc_reg_check_pkg.sv */
// Checker for the USB client register file testbench: a bit-exact predictor of
// the register map and an in-order store of the replies it expects.
// Depends on usbc_pkg.
`timescale 1ns / 1ps

package usbc_reg_check_pkg;
  import usbc_pkg::*;

  localparam int NUM_EP = NUM_ENDPOINTS_DEF;

  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  function automatic logic [19:0] word_off(int w);
    return 20'(w * 4);
  endfunction

  class reg_file_checker;
    logic [31:0] ctrl, iel, ieh;
    logic [24:0] otg;
    logic [26:0] p2;
    logic [1:0]  p3;
    logic [9:0]  ep0;
    logic [7:0]  ep_status [NUM_EP];
    logic [26:0] ep_cfg [NUM_EP];
    out_item_t   replies_due[$];
    int unsigned errors;

    function new();
      ctrl = '0;
      iel = '0;
      ieh = '0;
      otg = '0;
      p2 = P2_RESET;
      p3 = '0;
      ep0 = '0;
      foreach (ep_status[i]) begin
        ep_status[i] = '0;
        ep_cfg[i] = '0;
      end
      errors = 0;
    endfunction

    function automatic out_item_t predict_access(in_item_t it);
      out_item_t  r;
      int         wi, n;
      logic [31:0] d;
      logic [9:0] e0;
      logic [7:0] st;
      r = '0;
      d = it.write_data;
      if (it.offset >= MAP_END || it.offset[1:0] != 2'b00) begin
        r.access_error = 1'b1;
        return r;
      end
      wi = int'(it.offset[10:2]);
      if (wi >= int'(W_EPS) && wi < int'(W_EPS) + NUM_EP) begin
        n = wi - int'(W_EPS);
        if (it.action == ACC_WRITE) begin
          st = (d[7:0] & EPS_RW) | (ep_status[n] & EPS_STICKY);
          if (ep_cfg[n][EPC_DIR_IN]) st |= d[7:0] & EPS_STICKY;
          ep_status[n] = st;
        end else begin
          st = ep_status[n];
          if (ep_cfg[n][EPC_DIR_IN] && ep_cfg[n][EPC_ENABLE]) st |= EPS_IDLE;
          r.read_data = 32'(st);
        end
      end else if (wi >= int'(W_EPC) && wi < int'(W_EPC) + NUM_EP) begin
        n = wi - int'(W_EPC);
        if (it.action == ACC_WRITE) begin
          if (!ctrl[CTRL_ENABLE]) ep_cfg[n] = d[26:0];
        end else begin
          r.read_data = 32'(ep_cfg[n]);
        end
      end else if (it.action == ACC_WRITE) begin
        case (9'(wi))
          W_CTRL: ctrl = d & CTRL_RW;
          W_IEL:  iel = d;
          W_IEH:  ieh = d & IEH_RW;
          W_OTG:  otg = d[24:0] & OTG_RW;
          W_P2:   p2 = d[26:0] & P2_RW;
          W_P3:   p3 = d[1:0];
          W_EP0: begin
            e0 = (d[9:0] & EP0_RW) | (ep0 & EP0_SET) | (d[9:0] & EP0_SET);
            if (d[EP0_DONE]) e0[EP0_INPROG] = 1'b0;
            ep0 = e0;
          end
          default: ;
        endcase
      end else begin
        case (9'(wi))
          W_CTRL:  r.read_data = ctrl;
          W_IEL:   r.read_data = iel;
          W_IEH:   r.read_data = ieh;
          W_OTG:   r.read_data = 32'(otg);
          W_P2:    r.read_data = 32'(p2);
          W_P3:    r.read_data = 32'(p3);
          W_EP0:   r.read_data = 32'(ep0);
          default: r.read_data = '0;
        endcase
      end
      return r;
    endfunction

    function void note_access(in_item_t it);
      replies_due.push_back(predict_access(it));
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      if (replies_due.size() == 0) begin
        $error("reply with none due: read_data %h access_error %b",
               got.read_data, got.access_error);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %h, got %h", want.read_data, got.read_data);
        errors++;
      end
      if (got.access_error !== want.access_error) begin
        $error("access_error: expected %b, got %b", want.access_error, got.access_error);
        errors++;
      end
    endfunction

    function int pending();
      return replies_due.size();
    endfunction
  endclass

endpackage

/* sim/tb_usb_client_register_file_unit.sv */
// Testbench top for usb_client_register_file_unit: directed and random word
// accesses with random idling on both sides, replies checked in order.
// Depends on usbc_pkg, usbc_reg_check_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_usb_client_register_file_unit;
  import usbc_pkg::*;
  import usbc_reg_check_pkg::*;

  localparam int RANDOM_ITEMS = 1300;
  localparam int CYCLE_LIMIT  = 1000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  bit          no_idle = 1'b0;
  int unsigned cycles = 0;

  reg_file_checker chk = new();

  usb_client_register_file_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL usb_client_register_file_unit");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) chk.check_reply(out_item);
      if (in_valid && in_ready) chk.note_access(in_item);
    end
  end

  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always begin
    int g;
    out_ready <= 1'b1;
    repeat ($urandom_range(1, 20)) @(posedge clk);
    g = idle_len();
    if (g > 0) begin
      out_ready <= 1'b0;
      repeat (g) @(posedge clk);
    end
  end

  task automatic send_access(logic act, logic [19:0] off, logic [31:0] data);
    in_item_t it;
    int g;
    g = idle_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    it.action = act;
    it.offset = off;
    it.write_data = data;
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [19:0] pick_offset();
    logic [8:0] fixed_words [6];
    int r;
    fixed_words = '{W_CTRL, W_IEL, W_IEH, W_OTG, W_P2, W_P3};
    r = $urandom_range(0, 99);
    if (r < 15) return word_off(fixed_words[$urandom_range(0, 5)]);
    if (r < 25) return word_off(W_EP0);
    if (r < 50) return word_off(W_EPS + $urandom_range(0, NUM_EP - 1));
    if (r < 70) return word_off(W_EPC + $urandom_range(0, NUM_EP - 1));
    if (r < 78) return word_off($urandom_range(0, 20'h117));
    if (r < 86) return word_off($urandom_range(0, 20'h117)) | 20'($urandom_range(1, 3));
    if (r < 93) return 20'($urandom_range(20'h460, 20'hFFFFF));
    return 20'($urandom_range(0, 20'hFFFFF));
  endfunction

  initial begin
    logic [31:0] d;
    int r;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_access(ACC_READ,  word_off(W_P2), 32'h0);
    send_access(ACC_WRITE, word_off(W_CTRL), 32'hFFFF_FFFF);
    send_access(ACC_READ,  word_off(W_CTRL), 32'h0);
    // config frozen while enabled
    send_access(ACC_WRITE, word_off(W_EPC), 32'h0000_1001);
    send_access(ACC_READ,  word_off(W_EPC), 32'h0);
    send_access(ACC_WRITE, word_off(W_CTRL), 32'h0);
    send_access(ACC_WRITE, word_off(W_EPC), 32'hFFFF_FFFF);
    send_access(ACC_READ,  word_off(W_EPC), 32'h0);
    // IN endpoint: sticky set, idle flags on read, sticky kept
    send_access(ACC_WRITE, word_off(W_EPS), 32'hFFFF_FFFF);
    send_access(ACC_WRITE, word_off(W_EPS), 32'h0);
    send_access(ACC_READ,  word_off(W_EPS), 32'h0);
    // OUT endpoint: sticky refused
    send_access(ACC_WRITE, word_off(W_EPS + NUM_EP - 1), 32'hFFFF_FFFF);
    send_access(ACC_READ,  word_off(W_EPS + NUM_EP - 1), 32'h0);
    // endpoint 0: set bits, then transmit done clears in-progress
    send_access(ACC_WRITE, word_off(W_EP0), 32'h0000_032A);
    send_access(ACC_WRITE, word_off(W_EP0), 32'h0000_0004);
    send_access(ACC_READ,  word_off(W_EP0), 32'h0);
    send_access(ACC_WRITE, word_off(W_IEL), 32'hFFFF_FFFF);
    send_access(ACC_WRITE, word_off(W_IEH), 32'hFFFF_FFFF);
    send_access(ACC_WRITE, word_off(W_OTG), 32'hFFFF_FFFF);
    send_access(ACC_WRITE, word_off(W_P2), 32'hFFFF_FFFF);
    send_access(ACC_WRITE, word_off(W_P3), 32'hFFFF_FFFF);
    send_access(ACC_WRITE, 20'h0000C, 32'hFFFF_FFFF);
    send_access(ACC_READ,  20'h0000C, 32'h0);
    send_access(ACC_READ,  20'h0045C, 32'h0);
    send_access(ACC_WRITE, 20'h00002, 32'hFFFF_FFFF);
    send_access(ACC_READ,  MAP_END, 32'h0);
    send_access(ACC_READ,  20'hFFFFF, 32'h0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 19);
      d = (r == 0) ? 32'hFFFF_FFFF : (r == 1) ? 32'h0 : $urandom;
      send_access(1'($urandom_range(0, 1)), pick_offset(), d);
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;
    // let the monitor note the last item before counting what is due
    @(posedge clk);

    while (chk.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (chk.errors == 0)
      $display("PASS usb_client_register_file_unit");
    else
      $display("FAIL usb_client_register_file_unit");
    $finish;
  end

endmodule

/* usb_client_register_file_unit.f */
sv/usbc_pkg.sv
sv/usbc_decode.sv
sv/usbc_regs.sv
sv/usb_client_register_file_unit.sv
sim/usbc_reg_check_pkg.sv
sim/tb_usb_client_register_file_unit.sv
